[src/eqc_pkg.sv]
// Shared types and constants for the execution queue countdown block.
package eqc_pkg;

  // Table geometry
  localparam int SLOTS = 8;
  localparam int TAG_W = 32;
  localparam int WAIT_W = 16;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 16;

  // Request codes
  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_TICK   = 2'd1;
  localparam logic [1:0] REQ_REMOVE = 2'd2;
  localparam logic [1:0] REQ_FLUSH  = 2'd3;

  // Operation kinds
  localparam logic [1:0] OP_OTHER = 2'd0;
  localparam logic [1:0] OP_LOAD  = 2'd1;
  localparam logic [1:0] OP_STORE = 2'd2;

  // Error codes
  localparam logic [1:0] ERR_OK   = 2'd0;
  localparam logic [1:0] ERR_FULL = 2'd1;
  localparam logic [1:0] ERR_NONE = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_USE_CACHE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOAD_LAT  = 1'd1;

  // Reset value of the load latency register
  localparam logic [WAIT_W-1:0] LOAD_LAT_RESET = 16'd1;

  // Input beat
  typedef struct packed {
    logic [1:0]        req_type;
    logic [TAG_W-1:0]  inst_tag;
    logic [1:0]        op_kind;
    logic [WAIT_W-1:0] cache_latency;
  } item_in_t;

  // Result beat
  typedef struct packed {
    logic              removed_valid;
    logic [TAG_W-1:0]  removed_tag;
    logic [1:0]        error_code;
    logic              any_done;
  } item_out_t;

  // Configuration seen by the slot table
  typedef struct packed {
    logic              use_cache_latency;
    logic [WAIT_W-1:0] load_latency;
  } cfg_t;

endpackage

[src/eqc_slots.sv]
// Slot table: valid bits, tags and wait counters with the per-request update.
module eqc_slots (
  input  logic              clk,
  input  logic              rst,
  input  logic              go,
  input  eqc_pkg::item_in_t item,
  input  eqc_pkg::cfg_t     cfg,
  output eqc_pkg::item_out_t res
);

  logic [eqc_pkg::SLOTS-1:0]  slot_valid;
  logic [eqc_pkg::SLOTS-1:0]  slot_valid_next;
  logic [eqc_pkg::WAIT_W-1:0] slot_wait [eqc_pkg::SLOTS];
  logic [eqc_pkg::WAIT_W-1:0] slot_wait_next [eqc_pkg::SLOTS];
  logic [eqc_pkg::TAG_W-1:0]  slot_tag [eqc_pkg::SLOTS];
  logic [eqc_pkg::TAG_W-1:0]  slot_tag_next [eqc_pkg::SLOTS];

  logic [eqc_pkg::SLOTS-1:0]  zero_vec;
  logic [eqc_pkg::SLOTS-1:0]  zero_next;
  logic [eqc_pkg::SLOTS-1:0]  free_vec;
  logic [eqc_pkg::SLOTS-1:0]  done_vec;
  logic [eqc_pkg::SLOTS-1:0]  ins_oh;
  logic [eqc_pkg::SLOTS-1:0]  rm_oh;
  logic [eqc_pkg::WAIT_W-1:0] ins_wait;
  logic [eqc_pkg::TAG_W-1:0]  rm_tag;

  // Slot status vectors and lowest-set one-hot picks
  always_comb begin
    for (int i = 0; i < eqc_pkg::SLOTS; i++) begin
      zero_vec[i] = (slot_wait[i] == '0);
    end
    free_vec = ~slot_valid;
    done_vec = slot_valid & zero_vec;
    ins_oh   = free_vec & (~free_vec + eqc_pkg::SLOTS'(1));
    rm_oh    = done_vec & (~done_vec + eqc_pkg::SLOTS'(1));
  end

  // Initial wait of an inserted entry
  always_comb begin
    ins_wait = eqc_pkg::WAIT_W'(1);
    if (cfg.use_cache_latency) begin
      if (item.op_kind == eqc_pkg::OP_LOAD || item.op_kind == eqc_pkg::OP_STORE) begin
        ins_wait = item.cache_latency;
      end
    end else if (item.op_kind == eqc_pkg::OP_LOAD) begin
      ins_wait = cfg.load_latency;
    end
  end

  // Tag of the removed entry, selected by the one-hot pick
  always_comb begin
    rm_tag = '0;
    for (int i = 0; i < eqc_pkg::SLOTS; i++) begin
      rm_tag = rm_tag | (slot_tag[i] & {eqc_pkg::TAG_W{rm_oh[i]}});
    end
  end

  // Next table state and result
  always_comb begin
    slot_valid_next = slot_valid;
    for (int i = 0; i < eqc_pkg::SLOTS; i++) begin
      slot_wait_next[i] = slot_wait[i];
      slot_tag_next[i]  = slot_tag[i];
    end
    res.removed_valid = 1'b0;
    res.removed_tag   = '0;
    res.error_code    = eqc_pkg::ERR_OK;

    unique case (item.req_type)
      eqc_pkg::REQ_INSERT: begin
        if (free_vec == '0) begin
          res.error_code = eqc_pkg::ERR_FULL;
        end else begin
          slot_valid_next = slot_valid | ins_oh;
          for (int i = 0; i < eqc_pkg::SLOTS; i++) begin
            if (ins_oh[i]) begin
              slot_wait_next[i] = ins_wait;
              slot_tag_next[i]  = item.inst_tag;
            end
          end
        end
      end
      eqc_pkg::REQ_TICK: begin
        // Countdown holds at zero
        for (int i = 0; i < eqc_pkg::SLOTS; i++) begin
          if (slot_valid[i] && !zero_vec[i]) begin
            slot_wait_next[i] = slot_wait[i] - eqc_pkg::WAIT_W'(1);
          end
        end
      end
      eqc_pkg::REQ_REMOVE: begin
        if (done_vec == '0) begin
          res.error_code = eqc_pkg::ERR_NONE;
        end else begin
          slot_valid_next   = slot_valid & ~rm_oh;
          res.removed_valid = 1'b1;
          res.removed_tag   = rm_tag;
        end
      end
      eqc_pkg::REQ_FLUSH: begin
        slot_valid_next = '0;
      end
      default: begin
        slot_valid_next = slot_valid;
      end
    endcase

    for (int i = 0; i < eqc_pkg::SLOTS; i++) begin
      zero_next[i] = (slot_wait_next[i] == '0);
    end
    res.any_done = |(slot_valid_next & zero_next);
  end

  // Valid bits are control state; tags and waits are payload
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
    end else if (go) begin
      slot_valid <= slot_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      for (int i = 0; i < eqc_pkg::SLOTS; i++) begin
        slot_wait[i] <= slot_wait_next[i];
        slot_tag[i]  <= slot_tag_next[i];
      end
    end
  end

endmodule

[src/execution_queue_countdown.sv]
// Top level of the execution queue countdown: input register, slot table, result register.
//
// Takes one request beat in every cycle (busy stays low) and returns exactly one result
// beat via the input register and then the result register, with result_valid high for a
// single cycle. The block keeps a table of in-flight entries; an insert fills the lowest
// free slot, a tick counts every valid wait down toward zero, a remove frees the lowest
// finished entry, and a flush empties the table. The rate of one request per cycle is set
// by the combinational update of the slot table between the input and result registers.
// Results cannot be held off: the receiver must take each beat in the cycle it appears.
// Configuration writes take effect on the next request and belong in idle periods.
module execution_queue_countdown (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  eqc_pkg::item_in_t                item,
  output logic                             result_valid,
  output eqc_pkg::item_out_t               result,
  input  logic                             cfg_we,
  input  logic [eqc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [eqc_pkg::CFG_DATA_W-1:0]   cfg_data
);

  eqc_pkg::cfg_t      cfg;
  eqc_pkg::item_in_t  item_q;
  logic               item_q_valid;
  eqc_pkg::item_out_t res;

  assign busy = 1'b0;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.use_cache_latency <= 1'b0;
      cfg.load_latency      <= eqc_pkg::LOAD_LAT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        eqc_pkg::CFG_USE_CACHE: cfg.use_cache_latency <= cfg_data[0];
        eqc_pkg::CFG_LOAD_LAT:  cfg.load_latency      <= cfg_data;
        default:                cfg.load_latency      <= cfg.load_latency;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_q_valid <= 1'b0;
    end else begin
      item_q_valid <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      item_q <= item;
    end
  end

  eqc_slots u_slots (
    .clk  (clk),
    .rst  (rst),
    .go   (item_q_valid),
    .item (item_q),
    .cfg  (cfg),
    .res  (res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= item_q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_q_valid) begin
      result <= res;
    end
  end

endmodule

[test/eqc_checker.sv]
// Checker for the execution queue countdown: predicts each result beat and compares it.
module eqc_checker
  import eqc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic                  busy,
  input  item_in_t              item,
  input  logic                  result_valid,
  input  item_out_t             result,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    errors,
  output int                    pending
);

  // Shadow copy of the slot table and the mode registers
  cfg_t              mode;
  logic              entry_live [SLOTS];
  logic [WAIT_W-1:0] entry_left [SLOTS];
  logic [TAG_W-1:0]  entry_tag  [SLOTS];

  item_out_t due_results [$];

  initial begin
    errors  = 0;
    pending = 0;
  end

  task automatic report(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    errors++;
  endtask

  // Lowest live entry whose countdown has reached zero, or -1
  function automatic int lowest_done();
    for (int i = 0; i < SLOTS; i++) begin
      if (entry_live[i] && entry_left[i] == '0) return i;
    end
    return -1;
  endfunction

  // Apply one request to the shadow table and return the beat it should produce
  function automatic item_out_t apply_request(input item_in_t rq);
    item_out_t         r;
    int                slot;
    logic [WAIT_W-1:0] lat;
    r = '0;
    r.error_code = ERR_OK;
    slot = -1;
    case (rq.req_type)
      REQ_INSERT: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (!entry_live[i] && slot < 0) slot = i;
        end
        if (slot < 0) begin
          r.error_code = ERR_FULL;
        end else begin
          lat = WAIT_W'(1);
          if (mode.use_cache_latency) begin
            if (rq.op_kind == OP_LOAD || rq.op_kind == OP_STORE) lat = rq.cache_latency;
          end else if (rq.op_kind == OP_LOAD) begin
            lat = mode.load_latency;
          end
          entry_live[slot] = 1'b1;
          entry_tag[slot]  = rq.inst_tag;
          entry_left[slot] = lat;
        end
      end
      REQ_TICK: begin
        // countdown holds at zero
        for (int i = 0; i < SLOTS; i++) begin
          if (entry_live[i] && entry_left[i] != '0) entry_left[i] = entry_left[i] - WAIT_W'(1);
        end
      end
      REQ_REMOVE: begin
        slot = lowest_done();
        if (slot < 0) begin
          r.error_code = ERR_NONE;
        end else begin
          entry_live[slot] = 1'b0;
          r.removed_valid = 1'b1;
          r.removed_tag   = entry_tag[slot];
        end
      end
      default: begin
        for (int i = 0; i < SLOTS; i++) entry_live[i] = 1'b0;
      end
    endcase
    r.any_done = (lowest_done() >= 0);
    return r;
  endfunction

  // Compare retiring beats first, then predict the newly taken request
  always @(posedge clk) begin
    item_out_t want;
    if (rst) begin
      mode.use_cache_latency = 1'b0;
      mode.load_latency      = LOAD_LAT_RESET;
      for (int i = 0; i < SLOTS; i++) begin
        entry_live[i] = 1'b0;
        entry_left[i] = '0;
        entry_tag[i]  = '0;
      end
      due_results.delete();
    end else begin
      if (result_valid) begin
        if (due_results.size() == 0) begin
          report($sformatf("result beat %h with nothing outstanding", result));
        end else begin
          want = due_results.pop_front();
          if (result.removed_valid !== want.removed_valid)
            report($sformatf("removed_valid exp %b got %b",
                             want.removed_valid, result.removed_valid));
          if (result.removed_tag !== want.removed_tag)
            report($sformatf("removed_tag exp %h got %h", want.removed_tag, result.removed_tag));
          if (result.error_code !== want.error_code)
            report($sformatf("error_code exp %0d got %0d", want.error_code, result.error_code));
          if (result.any_done !== want.any_done)
            report($sformatf("any_done exp %b got %b", want.any_done, result.any_done));
        end
      end
      if (cfg_we) begin
        if (cfg_index == CFG_USE_CACHE) mode.use_cache_latency = cfg_data[0];
        else if (cfg_index == CFG_LOAD_LAT) mode.load_latency = cfg_data;
      end
      if (start && !busy) due_results.push_back(apply_request(item));
    end
    pending = due_results.size();
  end

endmodule

[test/tb_execution_queue_countdown.sv]
// Testbench top for the execution queue countdown: stimulus, configuration phases and verdict.
module tb_execution_queue_countdown;
  import eqc_pkg::*;

  localparam int CYCLE_LIMIT = 300000;

  logic                  clk;
  logic                  rst;
  logic                  start;
  logic                  busy;
  item_in_t              item;
  logic                  result_valid;
  item_out_t             result;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    errors;
  int                    pending;
  int                    cycles;

  execution_queue_countdown i_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .item         (item),
    .result_valid (result_valid),
    .result       (result),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  eqc_checker i_checker (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .item         (item),
    .result_valid (result_valid),
    .result       (result),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .errors       (errors),
    .pending      (pending)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Watchdog
  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic item_in_t req(input logic [1:0] kind_of_req, input logic [TAG_W-1:0] tag,
                                   input logic [1:0] op, input logic [WAIT_W-1:0] clat);
    item_in_t r;
    r.req_type      = kind_of_req;
    r.inst_tag      = tag;
    r.op_kind       = op;
    r.cache_latency = clat;
    return r;
  endfunction

  // Idle for a number of cycles, then present one beat and hold it until taken
  task automatic issue(input item_in_t it, input int gap);
    repeat (gap) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start <= 1'b1;
    item  <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Stop sending and wait until every outstanding beat has come back
  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  // Write both mode registers while the block is idle
  task automatic set_mode(input logic use_cache, input logic [WAIT_W-1:0] lat);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_USE_CACHE;
    cfg_data  <= CFG_DATA_W'(use_cache);
    @(negedge clk);
    cfg_index <= CFG_LOAD_LAT;
    cfg_data  <= lat;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Random request: mostly insert/tick/remove with short latencies, rare flush
  function automatic item_in_t random_req();
    item_in_t r;
    int       pick;
    pick = $urandom_range(0, 99);
    if (pick < 38)      r.req_type = REQ_INSERT;
    else if (pick < 68) r.req_type = REQ_TICK;
    else if (pick < 95) r.req_type = REQ_REMOVE;
    else                r.req_type = REQ_FLUSH;
    r.inst_tag = $urandom;
    r.op_kind  = 2'($urandom_range(0, 3));
    pick = $urandom_range(0, 19);
    if (pick < 16)       r.cache_latency = WAIT_W'($urandom_range(0, 3));
    else if (pick < 18)  r.cache_latency = WAIT_W'($urandom);
    else if (pick == 18) r.cache_latency = '1;
    else                 r.cache_latency = '0;
    return r;
  endfunction

  initial begin
    int          gap;
    int          idle_pct;
    logic        seg_cache [6];
    logic [15:0] seg_lat   [6];

    rst       = 1'b1;
    start     = 1'b0;
    item      = '0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    // Directed: reset mode (cache off, load latency at its reset value)
    issue(req(REQ_REMOVE, '0, OP_OTHER, '0), 0);          // nothing finished
    issue(req(REQ_INSERT, '0, OP_OTHER, '1), 0);
    issue(req(REQ_TICK, '1, OP_OTHER, '0), 0);
    issue(req(REQ_TICK, '0, OP_OTHER, '0), 0);            // holds at zero
    issue(req(REQ_REMOVE, '0, OP_OTHER, '0), 0);
    issue(req(REQ_INSERT, '1, OP_LOAD, '0), 0);
    issue(req(REQ_INSERT, 32'hA5A5_5A5A, OP_STORE, '1), 0);
    issue(req(REQ_INSERT, 32'h8000_0001, 2'd3, 16'h8001), 0); // kind three acts as other
    for (int i = 0; i < 5; i++) issue(req(REQ_INSERT, $urandom, OP_OTHER, '0), 0);
    issue(req(REQ_INSERT, 32'hDEAD_BEEF, OP_OTHER, '0), 0); // table full
    issue(req(REQ_TICK, '0, OP_OTHER, '0), 0);
    issue(req(REQ_REMOVE, '0, OP_OTHER, '0), 0);
    issue(req(REQ_FLUSH, '1, 2'd3, '1), 0);

    // Cache mode: memory ops take the supplied latency, zero finishes at once
    set_mode(1'b1, 16'd0);
    issue(req(REQ_INSERT, 32'h0000_FFFF, OP_LOAD, '0), 0);
    issue(req(REQ_INSERT, 32'hFFFF_0000, OP_STORE, '1), 0);
    issue(req(REQ_INSERT, 32'h1234_5678, OP_OTHER, '0), 0);
    issue(req(REQ_REMOVE, '0, OP_OTHER, '0), 0);
    issue(req(REQ_FLUSH, '0, OP_OTHER, '0), 0);

    // Largest load latency
    set_mode(1'b0, 16'hFFFF);
    issue(req(REQ_INSERT, 32'h5555_AAAA, OP_LOAD, '0), 0);
    issue(req(REQ_TICK, '0, OP_OTHER, '0), 0);
    issue(req(REQ_REMOVE, '0, OP_OTHER, '0), 0);
    issue(req(REQ_FLUSH, '0, OP_OTHER, '0), 0);

    // Zero load latency
    set_mode(1'b0, 16'd0);
    issue(req(REQ_INSERT, 32'hCAFE_F00D, OP_LOAD, '1), 0);
    issue(req(REQ_REMOVE, '0, OP_OTHER, '0), 0);

    // Random segments, each under its own mode setting
    seg_cache[0] = 1'b0; seg_lat[0] = 16'd2;
    seg_cache[1] = 1'b1; seg_lat[1] = 16'hFFFF;
    seg_cache[2] = 1'b0; seg_lat[2] = 16'd0;
    seg_cache[3] = 1'b1; seg_lat[3] = 16'($urandom);
    seg_cache[4] = 1'b0; seg_lat[4] = 16'($urandom_range(0, 5));
    seg_cache[5] = 1'b1; seg_lat[5] = 16'd0;
    for (int s = 0; s < 6; s++) begin
      set_mode(seg_cache[s], seg_lat[s]);
      idle_pct = (s < 2) ? 26 : (s < 4) ? 67 : 0;
      for (int n = 0; n < 88; n++) begin
        if (n == 44) drain();
        gap = 0;
        while (gap < 20 && $urandom_range(0, 99) < idle_pct) gap++;
        issue(random_req(), gap);
      end
    end

    drain();
    repeat (8) @(negedge clk);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

[filelist.f]
src/eqc_pkg.sv
src/eqc_slots.sv
src/execution_queue_countdown.sv
test/eqc_checker.sv
test/tb_execution_queue_countdown.sv
